/* rtl/core/beat_tone_generator_assert.svh */
// ----------------------------------------------------------------------------
// Beat tone generator assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEAT_TONE_GENERATOR_ASSERT_SVH
`define BEAT_TONE_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beat tone generator check failed");
`define BTG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("beat tone generator check failed");
`else
`define BTG_ASSERT_IMP(label, ante, cons)
`define BTG_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/btg_pkg.sv */
// ----------------------------------------------------------------------------
// Beat tone generator package
// Sequencer states, register indexes, mixing constants and the sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btg_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SWC_MUL,
        ST_SWC_DIV,
        ST_SWB_MUL,
        ST_SWB_DIV,
        ST_SIN,
        ST_TONE_MUL,
        ST_TONE_ACC,
        ST_ISO_SIN,
        ST_ISO_COS,
        ST_ISO_RAISE,
        ST_ISO_GATE,
        ST_ISO_FACT,
        ST_ISO_ROUND,
        ST_ISO_ACC,
        ST_INC_DIV,
        ST_OUT_L_MUL,
        ST_OUT_L,
        ST_OUT_R_MUL,
        ST_OUT_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    localparam logic [2:0] CFG_CARRIER_START   = 3'd0;
    localparam logic [2:0] CFG_CARRIER_END     = 3'd1;
    localparam logic [2:0] CFG_BEAT_START      = 3'd2;
    localparam logic [2:0] CFG_BEAT_END        = 3'd3;
    localparam logic [2:0] CFG_BEAT_MODE       = 3'd4;
    localparam logic [2:0] CFG_HARMONIC_LAYERS = 3'd5;
    localparam logic [2:0] CFG_LOUDNESS_GAIN   = 3'd6;
    localparam logic [2:0] CFG_SAMPLE_RATE     = 3'd7;

    localparam logic [1:0] MODE_BINAURAL   = 2'd0;
    localparam logic [1:0] MODE_MONAURAL   = 2'd1;
    localparam logic [1:0] MODE_ISOCHRONIC = 2'd2;

    localparam logic [15:0] CARRIER_MIN  = 16'd6400;
    localparam logic [15:0] CARRIER_MAX  = 16'd64000;
    localparam logic [15:0] BEAT_MAX     = 16'd40960;
    localparam logic [15:0] BEAT_ISO_MIN = 16'd103;
    localparam logic [21:0] HARM_MIN     = 22'd102400;
    localparam logic [21:0] HARM_MAX     = 22'd4096000;
    localparam logic [16:0] MONO_WEIGHT  = 17'd24904;
    localparam logic [16:0] ISO_WEIGHT   = 17'd40632;
    localparam logic [16:0] GATE_FLOOR   = 17'd7864;
    localparam logic [16:0] GATE_SPAN    = 17'd57672;

    function automatic logic [14:0] quarter_sine(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd3212;
            5'd2:    v = 15'd6393;
            5'd3:    v = 15'd9512;
            5'd4:    v = 15'd12540;
            5'd5:    v = 15'd15447;
            5'd6:    v = 15'd18205;
            5'd7:    v = 15'd20788;
            5'd8:    v = 15'd23170;
            5'd9:    v = 15'd25330;
            5'd10:   v = 15'd27246;
            5'd11:   v = 15'd28899;
            5'd12:   v = 15'd30274;
            5'd13:   v = 15'd31357;
            5'd14:   v = 15'd32138;
            5'd15:   v = 15'd32610;
            5'd16:   v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Quarter-wave table with linear interpolation, phase left-aligned to 32 bits
    function automatic logic signed [15:0] sine_q15(input logic [31:0] p);
        logic [30:0] w;
        logic [4:0]  idx;
        logic [15:0] fr;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [11:0] d;
        logic [27:0] dp;
        logic [15:0] v;
        w = {1'b0, p[29:0]};
        if (p[30])
        begin
            w = 31'h4000_0000 - w;
        end
        idx = w[30:26];
        fr  = w[25:10];
        lo  = quarter_sine(idx);
        hi  = quarter_sine(idx + 5'd1);
        d   = 12'(hi - lo);
        dp  = 28'(d) * 28'(fr);
        if (idx >= 5'd16)
        begin
            v = 16'd32767;
        end
        else
        begin
            v = {1'b0, lo} + 16'(dp >> 16);
        end
        return p[31] ? -signed'(v) : signed'(v);
    endfunction

    function automatic logic [16:0] layer_weight(input logic [1:0] layers,
                                                 input logic [1:0] col);
        logic [16:0] w;
        case ({layers, col})
            4'b01_00: w = 17'd47186;
            4'b10_00: w = 17'd43781;
            4'b10_01: w = 17'd3405;
            4'b11_00: w = 17'd42467;
            4'b11_01: w = 17'd3303;
            4'b11_10: w = 17'd1416;
            default:  w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/btg_div.sv */
// ----------------------------------------------------------------------------
// Beat tone generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btg_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 28
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num,
    input  logic [DEN_W-1:0]          den,
    output btg_pkg::div_status_t      status,
    output logic [NUM_W-1:0]          quot
);
    import btg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] q_reg;
    logic [NUM_W-1:0] q_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift the next numerator bit in, subtract where it fits
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = q_reg;

endmodule

/* rtl/core/beat_tone_generator.sv */
// ----------------------------------------------------------------------------
// Beat tone generator
// Stereo binaural, monaural and isochronic tones with swept carrier and beat.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | action, sample_index, frame_length
//  out     | out_valid / out_ready| left_sample, right_sample
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
//  The time a sample word takes is set mostly by the shared restoring divider
//  that forms both sweep quotients and every phase increment (2 to 4 of them),
//  one bit per cycle. A clear-phase word or a zero sample rate skips the
//  divider and goes straight to the output register.
//  in_ready drops for the whole of a word; a finished result waits in the
//  output register while the next word is taken.
`timescale 1ns / 1ps

module beat_tone_generator #(
    parameter int PHASE_BITS          = 32,
    parameter int MAX_FRAME_LENGTH    = 4096,
    parameter int MAX_HARMONIC_LAYERS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [11:0]        sample_index,
    input  logic [12:0]        frame_length,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data
);
    import btg_pkg::*;

`include "beat_tone_generator_assert.svh"

    localparam int NUM_W = PHASE_BITS + 22;
    localparam int DEN_W = 28;
    localparam logic [12:0] NMAX = (MAX_FRAME_LENGTH > 8191) ? 13'd8191
                                                             : 13'(MAX_FRAME_LENGTH);
    localparam logic [1:0] LAYERS_CAP = 2'(MAX_HARMONIC_LAYERS);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

    // configuration
    logic [15:0] carrier_start_reg;
    logic [15:0] carrier_end_reg;
    logic [15:0] beat_start_reg;
    logic [15:0] beat_end_reg;
    logic [1:0]  beat_mode_reg;
    logic [1:0]  harmonic_layers_reg;
    logic [14:0] loudness_gain_reg;
    logic [17:0] sample_rate_reg;

    // control
    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  slot_reg;
    logic [1:0]  slot_next;
    logic        launch_reg;
    logic        launch_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [PHASE_BITS-1:0] phase_reg [4];
    logic [PHASE_BITS-1:0] phase_next [4];

    // datapath
    logic [11:0]        idx_reg;
    logic [11:0]        idx_next;
    logic [12:0]        nm1_reg;
    logic [12:0]        nm1_next;
    logic [19:0]        car_reg;
    logic [19:0]        car_next;
    logic [15:0]        beat_reg;
    logic [15:0]        beat_next;
    logic signed [15:0] sin_reg;
    logic signed [15:0] sin_next;
    logic signed [15:0] c_reg;
    logic signed [15:0] c_next;
    logic signed [32:0] acc_l_reg;
    logic signed [32:0] acc_l_next;
    logic signed [32:0] acc_r_reg;
    logic signed [32:0] acc_r_next;
    logic signed [50:0] prod_reg;
    logic signed [50:0] prod_next;
    logic signed [15:0] res_l_reg;
    logic signed [15:0] res_l_next;
    logic signed [15:0] res_r_reg;
    logic signed [15:0] res_r_next;
    logic signed [15:0] left_sample_reg;
    logic signed [15:0] right_sample_reg;

    // combinational helpers
    logic        is_iso;
    logic        is_mono;
    logic        is_bin;
    logic [1:0]  lay_eff;
    logic [1:0]  last_slot;
    logic [15:0] cs_cl;
    logic [15:0] ce_cl;
    logic [15:0] bs_cl;
    logic [15:0] be_cl;
    logic [19:0] sw_s;
    logic [19:0] sw_e;
    logic signed [20:0] sw_diff;
    logic [20:0] sw_q;
    logic signed [20:0] sw_sq;
    logic [19:0] sw_res;
    logic [12:0] n_sat;
    logic [12:0] n_m1;
    logic [21:0] car3;
    logic [21:0] fifth_raw;
    logic [21:0] octave_raw;
    logic [21:0] f_sel;
    logic [PHASE_BITS-1:0] phase_sel;
    logic [PHASE_BITS-1:0] sine_arg;
    logic signed [15:0] sine_val;
    logic [16:0] raised_full;
    logic [16:0] factor;
    logic [16:0] tone_w;
    logic [1:0]  w_col;
    logic        prod_neg;
    logic [50:0] prod_mag;
    logic [50:0] r16;
    logic [50:0] r30;
    logic signed [15:0] g_val;
    logic signed [22:0] out_val;
    logic signed [15:0] out_sat;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic        in_div;
    logic        div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quot;
    div_status_t div_stat;
    logic        accept;
    logic        out_load;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid    = out_valid_reg;
    assign left_sample  = left_sample_reg;
    assign right_sample = right_sample_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // mode decode; the unused mode plays binaural
    assign is_iso  = (beat_mode_reg == MODE_ISOCHRONIC);
    assign is_mono = (beat_mode_reg == MODE_MONAURAL);
    assign is_bin  = !is_iso && !is_mono;

    always_comb
    begin
        lay_eff = (harmonic_layers_reg == 2'd0) ? 2'd1 : harmonic_layers_reg;
        if (lay_eff > LAYERS_CAP)
        begin
            lay_eff = LAYERS_CAP;
        end
    end
    assign last_slot = is_bin ? lay_eff : 2'd1;

    // clamp the sweep end points
    always_comb
    begin
        cs_cl = (carrier_start_reg < CARRIER_MIN) ? CARRIER_MIN :
                ((carrier_start_reg > CARRIER_MAX) ? CARRIER_MAX : carrier_start_reg);
        ce_cl = (carrier_end_reg < CARRIER_MIN) ? CARRIER_MIN :
                ((carrier_end_reg > CARRIER_MAX) ? CARRIER_MAX : carrier_end_reg);
        bs_cl = (beat_start_reg > BEAT_MAX) ? BEAT_MAX : beat_start_reg;
        be_cl = (beat_end_reg > BEAT_MAX) ? BEAT_MAX : beat_end_reg;
        if (is_iso && bs_cl < BEAT_ISO_MIN)
        begin
            bs_cl = BEAT_ISO_MIN;
        end
        if (is_iso && be_cl < BEAT_ISO_MIN)
        begin
            be_cl = BEAT_ISO_MIN;
        end
    end

    always_comb
    begin
        if (state_reg == ST_SWC_MUL || state_reg == ST_SWC_DIV)
        begin
            sw_s = {cs_cl, 4'b0};
            sw_e = {ce_cl, 4'b0};
        end
        else
        begin
            sw_s = 20'(bs_cl);
            sw_e = 20'(be_cl);
        end
    end
    assign sw_diff = signed'({1'b0, sw_e}) - signed'({1'b0, sw_s});
    assign sw_q    = (nm1_reg == 13'd0) ? 21'd0 : div_quot[20:0];
    assign sw_sq   = prod_neg ? -signed'(sw_q) : signed'(sw_q);
    assign sw_res  = 20'(signed'({1'b0, sw_s}) + sw_sq);

    // frame length and index saturation
    always_comb
    begin
        n_sat = (frame_length == 13'd0) ? 13'd1 : frame_length;
        if (n_sat > NMAX)
        begin
            n_sat = NMAX;
        end
        n_m1 = n_sat - 13'd1;
    end

    // tone frequencies, Q.10 Hz
    assign car3       = 22'(car_reg) + 22'({car_reg, 1'b0});
    assign fifth_raw  = car3 >> 1;
    assign octave_raw = 22'({car_reg, 1'b0});
    always_comb
    begin
        case (slot_reg)
            2'd0:    f_sel = is_iso ? 22'(car_reg) : 22'(car_reg) - 22'(beat_reg >> 1);
            2'd1:    f_sel = is_iso ? 22'(beat_reg) : 22'(car_reg) + 22'(beat_reg >> 1);
            2'd2:    f_sel = (fifth_raw < HARM_MIN) ? HARM_MIN :
                             ((fifth_raw > HARM_MAX) ? HARM_MAX : fifth_raw);
            default: f_sel = (octave_raw < HARM_MIN) ? HARM_MIN :
                             ((octave_raw > HARM_MAX) ? HARM_MAX : octave_raw);
        endcase
    end

    // sine of the selected phase
    assign phase_sel = phase_reg[slot_reg];
    assign sine_arg  = (state_reg == ST_ISO_COS) ? phase_sel + QUARTER : phase_sel;
    assign sine_val  = sine_q15(32'(sine_arg) << (32 - PHASE_BITS));

    // isochronic gate terms
    assign raised_full = 17'd32768 - 17'(sin_reg);
    assign factor      = GATE_FLOOR + 17'(prod_reg[30:15]);

    assign w_col  = (slot_reg < 2'd2) ? 2'd0 : slot_reg - 2'd1;
    assign tone_w = is_mono ? MONO_WEIGHT : layer_weight(lay_eff, w_col);

    // rounding, half away from zero
    assign prod_neg = prod_reg[50];
    assign prod_mag = prod_neg ? unsigned'(-prod_reg) : unsigned'(prod_reg);
    assign r16      = (prod_mag + (51'd1 << 15)) >> 16;
    assign r30      = (prod_mag + (51'd1 << 29)) >> 30;
    assign g_val    = prod_neg ? -signed'(r16[15:0]) : signed'(r16[15:0]);
    assign out_val  = prod_neg ? -signed'(r30[22:0]) : signed'(r30[22:0]);
    assign out_sat  = (out_val > 23'sd32767) ? 16'sh7FFF :
                      ((out_val < -23'sd32768) ? 16'sh8000 : out_val[15:0]);

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SWC_MUL, ST_SWB_MUL:
            begin
                mul_a = 33'(sw_diff);
                mul_b = signed'(18'(idx_reg));
            end
            ST_TONE_MUL:
            begin
                mul_a = 33'(sin_reg);
                mul_b = signed'({1'b0, tone_w});
            end
            ST_ISO_RAISE:
            begin
                mul_a = signed'(33'(raised_full[16:1]));
                mul_b = signed'({2'b0, raised_full[16:1]});
            end
            ST_ISO_GATE:
            begin
                mul_a = signed'(33'(prod_reg[29:15]));
                mul_b = signed'({1'b0, GATE_SPAN});
            end
            ST_ISO_FACT:
            begin
                mul_a = 33'(c_reg);
                mul_b = signed'({1'b0, factor});
            end
            ST_ISO_ROUND:
            begin
                mul_a = 33'(g_val);
                mul_b = signed'({1'b0, ISO_WEIGHT});
            end
            ST_OUT_L_MUL:
            begin
                mul_a = acc_l_reg;
                mul_b = signed'(18'(loudness_gain_reg));
            end
            ST_OUT_R_MUL:
            begin
                mul_a = acc_r_reg;
                mul_b = signed'(18'(loudness_gain_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider operands
    assign div_num   = (state_reg == ST_INC_DIV) ? NUM_W'(f_sel) << PHASE_BITS
                                                 : NUM_W'(prod_mag);
    assign div_den   = (state_reg == ST_INC_DIV) ? {sample_rate_reg, 10'b0}
                                                 : DEN_W'(nm1_reg);
    assign in_div    = (state_reg == ST_SWC_DIV || state_reg == ST_SWB_DIV
                        || state_reg == ST_INC_DIV);
    assign div_start = in_div && !launch_reg;

    btg_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_stat),
        .quot   (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action || sample_rate_reg == 18'd0) ? ST_DONE : ST_SWC_MUL;
                end
            end
            ST_SWC_MUL:   state_next = ST_SWC_DIV;
            ST_SWC_DIV:   state_next = div_stat.done ? ST_SWB_MUL : ST_SWC_DIV;
            ST_SWB_MUL:   state_next = ST_SWB_DIV;
            ST_SWB_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = is_iso ? ST_ISO_SIN : ST_SIN;
                end
            end
            ST_SIN:       state_next = ST_TONE_MUL;
            ST_TONE_MUL:  state_next = ST_TONE_ACC;
            ST_TONE_ACC:  state_next = (slot_reg == last_slot) ? ST_INC_DIV : ST_SIN;
            ST_ISO_SIN:   state_next = ST_ISO_COS;
            ST_ISO_COS:   state_next = ST_ISO_RAISE;
            ST_ISO_RAISE: state_next = ST_ISO_GATE;
            ST_ISO_GATE:  state_next = ST_ISO_FACT;
            ST_ISO_FACT:  state_next = ST_ISO_ROUND;
            ST_ISO_ROUND: state_next = ST_ISO_ACC;
            ST_ISO_ACC:   state_next = ST_INC_DIV;
            ST_INC_DIV:
            begin
                if (div_stat.done && slot_reg == last_slot)
                begin
                    state_next = ST_OUT_L_MUL;
                end
            end
            ST_OUT_L_MUL: state_next = ST_OUT_L;
            ST_OUT_L:     state_next = ST_OUT_R_MUL;
            ST_OUT_R_MUL: state_next = ST_OUT_R;
            ST_OUT_R:     state_next = ST_DONE;
            ST_DONE:      state_next = out_load ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        slot_next   = slot_reg;
        launch_next = launch_reg;
        idx_next    = idx_reg;
        nm1_next    = nm1_reg;
        car_next    = car_reg;
        beat_next   = beat_reg;
        sin_next    = sin_reg;
        c_next      = c_reg;
        acc_l_next  = acc_l_reg;
        acc_r_next  = acc_r_reg;
        prod_next   = prod_reg;
        res_l_next  = res_l_reg;
        res_r_next  = res_r_reg;
        for (int k = 0; k < 4; k++)
        begin
            phase_next[k] = phase_reg[k];
        end

        if (div_start)
        begin
            launch_next = 1'b1;
        end
        if (div_stat.done)
        begin
            launch_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = (sample_index > n_m1[11:0] || n_m1[12]) ?
                                 ((n_m1[12]) ? sample_index : n_m1[11:0]) : sample_index;
                    nm1_next   = n_m1;
                    slot_next  = 2'd0;
                    acc_l_next = '0;
                    acc_r_next = '0;
                    res_l_next = '0;
                    res_r_next = '0;
                    if (action)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            phase_next[k] = '0;
                        end
                    end
                end
            end
            ST_SWC_MUL, ST_SWB_MUL, ST_TONE_MUL, ST_ISO_RAISE, ST_ISO_GATE,
            ST_ISO_FACT, ST_ISO_ROUND, ST_OUT_L_MUL, ST_OUT_R_MUL:
            begin
                prod_next = mul_p;
            end
            ST_SWC_DIV:
            begin
                if (div_stat.done)
                begin
                    car_next = sw_res;
                end
            end
            ST_SWB_DIV:
            begin
                if (div_stat.done)
                begin
                    beat_next = sw_res[15:0];
                end
            end
            ST_SIN:
            begin
                sin_next = sine_val;
            end
            ST_TONE_ACC:
            begin
                // left tone to the left, right tone to the right, layers to both; monaural to both
                if (is_mono || slot_reg != 2'd1)
                begin
                    acc_l_next = acc_l_reg + prod_reg[32:0];
                end
                if (is_mono || slot_reg != 2'd0)
                begin
                    acc_r_next = acc_r_reg + prod_reg[32:0];
                end
                slot_next = (slot_reg == last_slot) ? 2'd0 : slot_reg + 2'd1;
            end
            ST_ISO_SIN:
            begin
                c_next    = sine_val;
                slot_next = 2'd1;
            end
            ST_ISO_COS:
            begin
                sin_next = sine_val;
            end
            ST_ISO_ACC:
            begin
                acc_l_next = prod_reg[32:0];
                acc_r_next = prod_reg[32:0];
                slot_next  = 2'd0;
            end
            ST_INC_DIV:
            begin
                if (div_stat.done)
                begin
                    phase_next[slot_reg] = phase_reg[slot_reg] + div_quot[PHASE_BITS-1:0];
                    slot_next = (slot_reg == last_slot) ? 2'd0 : slot_reg + 2'd1;
                end
            end
            ST_OUT_L:
            begin
                res_l_next = out_sat;
            end
            ST_OUT_R:
            begin
                res_r_next = out_sat;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            slot_reg            <= 2'd0;
            launch_reg          <= 1'b0;
            out_valid_reg       <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                phase_reg[k] <= '0;
            end
            carrier_start_reg   <= 16'd12800;
            carrier_end_reg     <= 16'd12800;
            beat_start_reg      <= 16'd10240;
            beat_end_reg        <= 16'd10240;
            beat_mode_reg       <= MODE_BINAURAL;
            harmonic_layers_reg <= 2'd1;
            loudness_gain_reg   <= 15'd16384;
            sample_rate_reg     <= 18'd48000;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < 4; k++)
            begin
                phase_reg[k] <= phase_next[k];
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CARRIER_START:   carrier_start_reg   <= cfg_data[15:0];
                    CFG_CARRIER_END:     carrier_end_reg     <= cfg_data[15:0];
                    CFG_BEAT_START:      beat_start_reg      <= cfg_data[15:0];
                    CFG_BEAT_END:        beat_end_reg        <= cfg_data[15:0];
                    CFG_BEAT_MODE:       beat_mode_reg       <= cfg_data[1:0];
                    CFG_HARMONIC_LAYERS: harmonic_layers_reg <= cfg_data[1:0];
                    CFG_LOUDNESS_GAIN:   loudness_gain_reg   <= cfg_data[14:0];
                    CFG_SAMPLE_RATE:     sample_rate_reg     <= cfg_data;
                    default:             sample_rate_reg     <= sample_rate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        nm1_reg   <= nm1_next;
        car_reg   <= car_next;
        beat_reg  <= beat_next;
        sin_reg   <= sin_next;
        c_reg     <= c_next;
        acc_l_reg <= acc_l_next;
        acc_r_reg <= acc_r_next;
        prod_reg  <= prod_next;
        res_l_reg <= res_l_next;
        res_r_reg <= res_r_next;
        if (out_load)
        begin
            left_sample_reg  <= res_l_reg;
            right_sample_reg <= res_r_reg;
        end
    end

    `BTG_ASSERT_IMP(a_accept_div_idle, accept, !div_stat.busy)
    `BTG_ASSERT_IMP(a_done_in_div, div_stat.done, in_div)
    `BTG_ASSERT_NXT(a_result_loaded, out_load, out_valid_reg && state_reg == ST_IDLE)
    `BTG_ASSERT_IMP(a_slot_bound, state_reg == ST_TONE_ACC || state_reg == ST_INC_DIV, slot_reg <= last_slot)

endmodule
